// ===== rtl/core/zmg_pkg.sv =====
`timescale 1ns / 1ps
package zmg_pkg;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_KERNEL  = 15;
    localparam int PIXEL_BITS  = 16;
    localparam int COEF_BITS   = 24;
    localparam int RES_BITS    = 32;
    localparam int CFG_BITS    = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = 16;
    localparam int WID_BITS    = COL_BITS + 1;
    localparam int KER_BITS    = $clog2(MAX_KERNEL + 1);
    localparam int LINE_ROWS   = MAX_KERNEL - 1;
    localparam int SLOT_BITS   = $clog2(LINE_ROWS);
    localparam int LINE_DEPTH  = LINE_ROWS * MAX_WIDTH;
    localparam int LADDR_BITS  = SLOT_BITS + COL_BITS;
    localparam int TABLE_SIZE  = MAX_KERNEL * MAX_KERNEL;
    localparam int CIDX_BITS   = 8;
    localparam int CADDR_BITS  = $clog2(TABLE_SIZE);
    localparam int PROD_BITS   = PIXEL_BITS + 1 + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + $clog2(TABLE_SIZE) + 1;
    localparam int FRAC_DROP   = 14;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_KSIZE  = 2'd2,
        CFG_CLIP   = 2'd3
    } t_cfg_idx;

    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic vld;
        logic clr;
    } t_mac_ctl;
endpackage

// ===== rtl/core/zmg_if.sv =====
`timescale 1ns / 1ps
interface zmg_in_if import zmg_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [CIDX_BITS-1:0]         coef_index;
    logic signed [COEF_BITS-1:0]  coef_value;
    logic [PIXEL_BITS-1:0]        pixel_value;
    modport source(output valid, operation, coef_index, coef_value, pixel_value,
                   input ready);
    modport sink(input valid, operation, coef_index, coef_value, pixel_value,
                 output ready);
endinterface

interface zmg_out_if import zmg_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [COL_BITS-1:0]         center_x;
    logic [ROW_BITS-1:0]         center_y;
    logic signed [RES_BITS-1:0]  filtered_value;
    modport source(output valid, center_x, center_y, filtered_value, input ready);
    modport sink(input valid, center_x, center_y, filtered_value, output ready);
endinterface

interface zmg_cfg_if import zmg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          index;
    logic [CFG_BITS-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/zmg_mac.sv =====
`timescale 1ns / 1ps
module zmg_mac import zmg_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mac_ctl                    i_ctl,
    input  logic [PIXEL_BITS-1:0]       i_pix,
    input  logic signed [COEF_BITS-1:0] i_coef,
    input  logic                        i_clip,
    output logic                        o_busy,
    output logic signed [RES_BITS-1:0]  o_result
);
    logic signed [PROD_BITS-1:0] r_prod;
    logic                        r_pv;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  w_rnd;
    logic signed [ACC_BITS-FRAC_DROP-1:0] w_q;
    logic signed [RES_BITS-1:0]  w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prod <= $signed({1'b0, i_pix}) * i_coef;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_BITS'(r_prod);
        end
    end

    // round half up to q.8, saturate, optional clip
    always_comb begin
        w_rnd = r_acc + ACC_BITS'(1 << (FRAC_DROP - 1));
        w_q   = w_rnd[ACC_BITS-1:FRAC_DROP];
        if (w_q > $signed((ACC_BITS-FRAC_DROP)'({1'b0, {(RES_BITS-1){1'b1}}}))) begin
            w_sat = {1'b0, {(RES_BITS-1){1'b1}}};
        end else if (w_q < -$signed((ACC_BITS-FRAC_DROP)'({1'b1, {(RES_BITS-1){1'b0}}}))) begin
            w_sat = {1'b1, {(RES_BITS-1){1'b0}}};
        end else begin
            w_sat = w_q[RES_BITS-1:0];
        end
        o_result = (i_clip && w_sat[RES_BITS-1]) ? '0 : w_sat;
    end

    assign o_busy = r_pv;
endmodule

// ===== rtl/core/zero_mean_gaussian_convolution.sv =====
`timescale 1ns / 1ps
// Zero-mean Gaussian matched filter over a raster pixel stream. Load the K*K
// signed Q1.22 coefficients (row-major) with coefficient words, then send
// pixels in raster order; each pixel whose K by K window lies inside the frame
// yields one saturated signed Q23.8 word with its center coordinates. A
// coefficient word or border pixel is taken when idle; a pixel with a result
// stalls input until registered, with a line-store read and a multiply per
// kernel tap. The line store (14 rows of 4096 pixels) and the coefficient
// table are not cleared at reset: load all coefficients before the first frame.
module zero_mean_gaussian_convolution import zmg_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    zmg_cfg_if.sink    i_cfg,
    zmg_in_if.sink     i_in,
    zmg_out_if.source  o_out
);
    t_state r_state, n_state;

    logic [WID_BITS-1:0]   r_width;
    logic [ROW_BITS-1:0]   r_height;
    logic [KER_BITS-1:0]   r_ksize;
    logic                  r_clip;

    logic [COL_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]   r_row;
    logic [SLOT_BITS-1:0]  r_slot;

    logic [COL_BITS-1:0]   r_cc;
    logic [ROW_BITS-1:0]   r_cr;
    logic [KER_BITS-1:0]   r_i, r_j;
    logic [COL_BITS-1:0]   r_rcol;
    logic [SLOT_BITS-1:0]  r_rslot;
    logic [CADDR_BITS-1:0] r_ca;
    logic                  r_v1;

    logic [PIXEL_BITS-1:0]       m_line [LINE_DEPTH];
    logic signed [COEF_BITS-1:0] m_coef [TABLE_SIZE];
    logic [PIXEL_BITS-1:0]       r_pix_q;
    logic signed [COEF_BITS-1:0] r_coef_q;
    logic [PIXEL_BITS-1:0]       r_old_q;
    logic                        r_old_v;
    logic [PIXEL_BITS-1:0]       r_old [MAX_KERNEL];

    logic                  r_ovalid;
    logic [COL_BITS-1:0]   r_ox;
    logic [ROW_BITS-1:0]   r_oy;
    logic signed [RES_BITS-1:0] r_oval;

    logic [WID_BITS-1:0]   w_w;
    logic [ROW_BITS-1:0]   w_h;
    logic [KER_BITS-1:0]   w_k;
    logic [KER_BITS-1:0]   w_half;
    logic [CADDR_BITS-1:0] w_kk;

    logic                  w_acc_in, w_pix_acc, w_coef_acc;
    logic [COL_BITS-1:0]   w_c;
    logic [ROW_BITS-1:0]   w_r;
    logic [SLOT_BITS-1:0]  w_s;
    logic [ROW_BITS:0]     w_rp;
    logic [COL_BITS-1:0]   n_col;
    logic [ROW_BITS-1:0]   n_row;
    logic [SLOT_BITS-1:0]  n_slot;
    logic [ROW_BITS:0]     w_rn;
    logic                  w_emit, w_start, w_last, w_ld, w_rd;
    logic                  w_mac_busy;
    logic signed [RES_BITS-1:0] w_res;
    t_mac_ctl              w_ctl;

    function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
        slot_inc = (s == SLOT_BITS'(LINE_ROWS - 1)) ? '0 : s + 1'b1;
    endfunction

    // effective settings
    always_comb begin
        if (r_width == '0) begin
            w_w = WID_BITS'(1);
        end else if (r_width > WID_BITS'(MAX_WIDTH)) begin
            w_w = WID_BITS'(MAX_WIDTH);
        end else begin
            w_w = r_width;
        end
        w_h    = (r_height == '0) ? ROW_BITS'(1) : r_height;
        w_k    = r_ksize | KER_BITS'(1);
        w_half = w_k >> 1;
        w_kk   = CADDR_BITS'(w_k * w_k);
    end

    assign w_acc_in   = i_in.valid && i_in.ready;
    assign w_pix_acc  = w_acc_in && (i_in.operation == OP_PIXEL);
    assign w_coef_acc = w_acc_in && (i_in.operation == OP_COEF);

    // raster position of the incoming pixel and of the next one
    always_comb begin
        w_c  = r_col;
        w_rp = {1'b0, r_row};
        w_s  = r_slot;
        if ({1'b0, r_col} >= w_w) begin
            w_c  = '0;
            w_rp = {1'b0, r_row} + 1'b1;
            w_s  = slot_inc(r_slot);
        end
        if (w_rp >= {1'b0, w_h}) begin
            w_r = '0;
            w_s = '0;
        end else begin
            w_r = w_rp[ROW_BITS-1:0];
        end
        w_emit = ({1'b0, w_c} + 1'b1 >= WID_BITS'(w_k))
              && ({1'b0, w_r} + 1'b1 >= (ROW_BITS+1)'(w_k));
        n_col  = w_c + 1'b1;
        n_row  = w_r;
        n_slot = w_s;
        w_rn   = {1'b0, w_r} + 1'b1;
        if ({1'b0, w_c} + 1'b1 >= w_w) begin
            n_col  = '0;
            if (w_rn >= {1'b0, w_h}) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = w_rn[ROW_BITS-1:0];
                n_slot = slot_inc(w_s);
            end
        end
    end

    assign w_start = w_pix_acc && w_emit;
    assign w_last  = (r_i == w_k - 1'b1) && (r_j == w_k - 1'b1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_start) n_state = S_RUN;
            S_RUN:   if (w_last) n_state = S_DRAIN;
            S_DRAIN: if (!r_v1 && !w_mac_busy) n_state = S_DONE;
            S_DONE:  if (!r_ovalid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        w_rd       = (r_state == S_RUN);
        w_ld       = (r_state == S_DONE) && (!r_ovalid || o_out.ready);
        w_ctl.vld  = r_v1;
        w_ctl.clr  = w_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= WID_BITS'(4096);
            r_height <= ROW_BITS'(4096);
            r_ksize  <= KER_BITS'(11);
            r_clip   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
            r_v1     <= 1'b0;
            r_old_v  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_rd;
            r_old_v <= w_pix_acc;
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_WIDTH:  r_width  <= i_cfg.data[WID_BITS-1:0];
                    CFG_HEIGHT: r_height <= i_cfg.data[ROW_BITS-1:0];
                    CFG_KSIZE:  r_ksize  <= i_cfg.data[KER_BITS-1:0];
                    CFG_CLIP:   r_clip   <= i_cfg.data[0];
                    default:    r_clip   <= r_clip;
                endcase
            end
            if (w_pix_acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_slot <= n_slot;
            end
            if (w_ld) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // tap sequencer: rows outer, columns inner, coefficients in reverse
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cc    <= w_c;
            r_cr    <= w_r;
            r_i     <= '0;
            r_j     <= '0;
            r_rcol  <= w_c;
            r_rslot <= w_s;
            r_ca    <= w_kk - 1'b1;
        end else if (w_rd) begin
            r_ca <= r_ca - 1'b1;
            if (r_j == w_k - 1'b1) begin
                r_j     <= '0;
                r_i     <= r_i + 1'b1;
                r_rcol  <= r_cc;
                r_rslot <= (r_rslot == '0) ? SLOT_BITS'(LINE_ROWS - 1) : r_rslot - 1'b1;
            end else begin
                r_j    <= r_j + 1'b1;
                r_rcol <= r_rcol - 1'b1;
            end
        end
    end

    // read-first write keeps the values replaced by the current row
    always_ff @(posedge i_clk) begin
        if (w_pix_acc) begin
            r_old_q            <= m_line[{w_s, w_c}];
            m_line[{w_s, w_c}] <= i_in.pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_old_v) begin
            r_old[0] <= r_old_q;
            for (int j = 1; j < MAX_KERNEL; j++) r_old[j] <= r_old[j-1];
        end
    end

    // oldest window row shares its slot with the current row
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            if (r_i == KER_BITS'(LINE_ROWS)) begin
                r_pix_q <= r_old[r_j];
            end else begin
                r_pix_q <= m_line[{r_rslot, r_rcol}];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_coef_acc && (i_in.coef_index < CIDX_BITS'(TABLE_SIZE))) begin
            m_coef[i_in.coef_index[CADDR_BITS-1:0]] <= i_in.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_coef_q <= m_coef[r_ca];
        end
    end

    zmg_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_pix    (r_pix_q),
        .i_coef   (r_coef_q),
        .i_clip   (r_clip),
        .o_busy   (w_mac_busy),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_ox   <= r_cc - COL_BITS'(w_half);
            r_oy   <= r_cr - ROW_BITS'(w_half);
            r_oval <= w_res;
        end
    end

    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_ovalid;
    assign o_out.center_x       = r_ox;
    assign o_out.center_y       = r_oy;
    assign o_out.filtered_value = r_oval;

    a_read_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("tap read outside run");
    a_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_i < w_k && r_j < w_k))
        else $error("tap counter past kernel");
    a_coef_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_ca < CADDR_BITS'(TABLE_SIZE)))
        else $error("coefficient address out of table");
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_BITS'(LINE_ROWS))
        else $error("line slot out of range");
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld |=> r_ovalid && r_state == S_IDLE)
        else $error("result not registered");
endmodule
